[src/sbdm_pkg.sv]
// shared types and constants for the backward snr dawg match counter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sbdm_pkg;

   localparam int TEXT_DEPTH_DEFAULT = 4096;
   localparam int PATTERN_MAX = 32;
   localparam int ALPHABET = 256;
   localparam int COUNT_W = 13;
   localparam int CSR_W = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN = 3'd4;

   // byte 0 of the pattern sits in the low bits
   typedef logic [PATTERN_MAX-1:0][7:0] pattern_type;

   typedef struct packed {
      logic [4:0] start;
      logic [5:0] len;
   } window_type;

endpackage

[src/sbdm_if.sv]
// valid/ready channels of the match counter
// depends on nothing; used by backward_snr_dawg_match_count_top
`timescale 1ns / 1ps

interface sbdm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_text;

   modport source (output valid, text_byte, last_text, input ready);
   modport sink (input valid, text_byte, last_text, output ready);
endinterface

interface sbdm_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] match_count;
   logic        text_overflow;

   modport source (output valid, match_count, text_overflow, input ready);
   modport sink (input valid, match_count, text_overflow, output ready);
endinterface

[src/sbdm_table.sv]
// window finder and byte-to-position table for the match counter
// depends on sbdm_pkg; the search engine reads the table through its read port
`timescale 1ns / 1ps

module sbdm_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sbdm_pkg::pattern_type pattern,
   input  logic [5:0]            pat_len,
   input  logic [7:0]            rd_addr,
   output logic                  rd_hit,
   output logic [4:0]            rd_pos,
   output sbdm_pkg::window_type  window,
   output logic                  done
);
   import sbdm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [ALPHABET-1:0] seen_ff, seen_in;
   logic [ALPHABET-1:0] valid_ff;
   logic [4:0]          i_ff, i_in, j_ff, j_in, best_st_ff, best_st_in;
   logic [5:0]          best_ff, best_in, k_ff, k_in;
   logic [7:0]          f, pj;
   logic [4:0]          jn;
   logic [5:0]          cur_len;
   logic                tbl_we;
   logic [7:0]          tbl_wa;
   logic [4:0]          tbl_mem [ALPHABET];

   assign f  = pattern[i_ff];
   assign pj = pattern[j_ff];

   always_comb begin
      state_in   = state_ff;
      seen_in    = seen_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      best_in    = best_ff;
      best_st_in = best_st_ff;
      k_in       = k_ff;
      jn         = j_ff;
      cur_len    = '0;
      tbl_we     = 1'b0;
      tbl_wa     = pattern[5'(best_st_ff + k_ff[4:0])];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               seen_in    = '0;
               i_in       = '0;
               j_in       = '0;
               best_in    = '0;
               best_st_in = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (seen_ff[f] && pj != f) begin
               // slide the left edge past the earlier copy
               seen_in[pj] = 1'b0;
               j_in        = j_ff + 5'd1;
            end else begin
               jn          = seen_ff[f] ? j_ff + 5'd1 : j_ff;
               seen_in[f]  = 1'b1;
               j_in        = jn;
               cur_len     = {1'b0, i_ff} - {1'b0, jn} + 6'd1;
               if (cur_len > best_ff) begin
                  best_in    = cur_len;
                  best_st_in = jn;
               end
               if ({1'b0, i_ff} == pat_len - 6'd1) begin
                  k_in     = '0;
                  state_in = ST_FILL;
               end else begin
                  i_in = i_ff + 5'd1;
               end
            end
         end
         ST_FILL: begin
            if (k_ff == best_ff) begin
               state_in = ST_DONE;
            end else begin
               tbl_we = 1'b1;
               k_in   = k_ff + 6'd1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         best_ff    <= '0;
         best_st_ff <= '0;
      end else begin
         state_ff   <= state_in;
         best_ff    <= best_in;
         best_st_ff <= best_st_in;
         if (state_ff == ST_IDLE && start) begin
            valid_ff <= '0;
         end else if (tbl_we) begin
            valid_ff[tbl_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      seen_ff <= seen_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= k_ff[4:0];
      end
      rd_pos <= tbl_mem[rd_addr];
      rd_hit <= valid_ff[rd_addr];
   end

   assign window.start = best_st_ff;
   assign window.len   = best_ff;
   assign done         = (state_ff == ST_DONE);

   a_left_edge: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> j_ff <= i_ff)
      else $error("window left edge passed right edge");
   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> (best_ff != 6'd0 && best_ff <= pat_len))
      else $error("window length out of range");
   a_fill_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> k_ff <= best_ff)
      else $error("table fill overran the window");
endmodule

[src/sbdm_search.sv]
// backward skip search engine with one shared byte comparator
// depends on sbdm_pkg; reads the text store and the position table of sbdm_table
`timescale 1ns / 1ps

module sbdm_search #(
   parameter int TEXT_DEPTH = sbdm_pkg::TEXT_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  sbdm_pkg::pattern_type          pattern,
   input  logic [5:0]                     pat_len,
   input  sbdm_pkg::window_type           window,
   input  logic [$clog2(TEXT_DEPTH+1)-1:0] text_len,
   output logic [$clog2(TEXT_DEPTH)-1:0]  text_addr,
   input  logic [7:0]                     text_q,
   output logic [7:0]                     tbl_addr,
   input  logic                           tbl_hit,
   input  logic [4:0]                     tbl_pos,
   output logic                           done,
   output logic [sbdm_pkg::COUNT_W-1:0]   count
);
   import sbdm_pkg::*;

   localparam int AW = $clog2(TEXT_DEPTH);
   localparam int JW = AW + 2;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_TEST    = 4'd1;
   localparam logic [3:0] ST_SK_RD   = 4'd2;
   localparam logic [3:0] ST_SK_TB   = 4'd3;
   localparam logic [3:0] ST_SK_CHK  = 4'd4;
   localparam logic [3:0] ST_BK_RD   = 4'd5;
   localparam logic [3:0] ST_BK_CMP  = 4'd6;
   localparam logic [3:0] ST_RESOLVE = 4'd7;
   localparam logic [3:0] ST_VR_RD   = 4'd8;
   localparam logic [3:0] ST_VR_CMP  = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [JW-1:0]      j_ff, j_in, s_ff, s_in;
   logic [4:0]         i_ff, i_in;
   logic [5:0]         k_ff, k_in, q_ff, q_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               in_store_ff, in_store_in;
   logic [7:0]         sent_ff, sent_in;
   logic [JW-1:0]      n_ext, offset, rd_pos, rd_rel, len_ext;
   logic [7:0]         text_byte, cmp_pat;
   logic               cmp_eq;

   assign n_ext     = JW'(text_len);
   assign len_ext   = JW'(window.len);
   assign offset    = JW'(window.start) + len_ext - JW'(1);
   assign text_byte = in_store_ff ? text_q : sent_ff;

   // the one byte comparator, shared by the suffix check and verification
   assign cmp_pat = (state_ff == ST_BK_CMP) ? pattern[5'(window.start + i_ff - k_ff[4:0])]
                                            : pattern[q_ff[4:0]];
   assign cmp_eq  = (cmp_pat == text_byte);

   always_comb begin
      case (state_ff)
         ST_BK_RD: rd_pos = j_ff - JW'(k_ff);
         ST_VR_RD: rd_pos = s_ff + JW'(q_ff);
         default:  rd_pos = j_ff;
      endcase
      rd_rel = rd_pos - n_ext;
   end

   assign text_addr = rd_pos[AW-1:0];
   assign tbl_addr  = text_byte;

   always_comb begin
      state_in    = state_ff;
      j_in        = j_ff;
      s_in        = s_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      q_in        = q_ff;
      count_in    = count_ff;
      // past the text end the pattern reads as a sentinel, then zeros
      in_store_in = (rd_pos < n_ext);
      sent_in     = (rd_rel < JW'(pat_len)) ? pattern[rd_rel[4:0]] : 8'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               j_in     = offset;
               count_in = '0;
               state_in = ST_TEST;
            end
         end
         ST_TEST:   state_in = (j_ff < n_ext) ? ST_SK_RD : ST_DONE;
         ST_SK_RD:  state_in = ST_SK_TB;
         ST_SK_TB:  state_in = ST_SK_CHK;
         ST_SK_CHK: begin
            if (!tbl_hit) begin
               j_in     = j_ff + len_ext;
               state_in = ST_SK_RD;
            end else begin
               i_in     = tbl_pos;
               k_in     = 6'd1;
               state_in = ST_BK_RD;
            end
         end
         ST_BK_RD: state_in = (k_ff > {1'b0, i_ff}) ? ST_RESOLVE : ST_BK_CMP;
         ST_BK_CMP: begin
            if (cmp_eq) begin
               k_in     = k_ff + 6'd1;
               state_in = ST_BK_RD;
            end else begin
               j_in     = j_ff + len_ext;
               state_in = ST_TEST;
            end
         end
         ST_RESOLVE: begin
            if (k_ff == window.len) begin
               s_in = j_ff - offset;
               if (j_ff - offset + JW'(pat_len) <= n_ext) begin
                  q_in     = '0;
                  state_in = ST_VR_RD;
               end else begin
                  j_in     = j_ff + len_ext;
                  state_in = ST_TEST;
               end
            end else begin
               j_in     = j_ff - JW'(k_ff) + len_ext;
               state_in = ST_TEST;
            end
         end
         ST_VR_RD: begin
            if (q_ff == pat_len) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               j_in     = j_ff + len_ext;
               state_in = ST_TEST;
            end else begin
               state_in = ST_VR_CMP;
            end
         end
         ST_VR_CMP: begin
            if (cmp_eq) begin
               q_in     = q_ff + 6'd1;
               state_in = ST_VR_RD;
            end else begin
               j_in     = j_ff + len_ext;
               state_in = ST_TEST;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      s_ff        <= s_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      q_ff        <= q_in;
      count_ff    <= count_in;
      in_store_ff <= in_store_in;
      sent_ff     <= sent_in;
   end

   assign done  = (state_ff == ST_DONE);
   assign count = count_ff;

   a_verify_in_text: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_VR_CMP |-> $past(in_store_in))
      else $error("verification read outside the stored text");
   a_suffix_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BK_CMP |-> (k_ff != 6'd0 && k_ff <= {1'b0, i_ff}))
      else $error("suffix check index out of range");
   a_verify_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_VR_CMP |-> q_ff < pat_len)
      else $error("verification index out of range");
endmodule

[src/backward_snr_dawg_match_count_top.sv]
// top level of the backward snr dawg match counter: csr, text store, sequencing
// depends on sbdm_pkg, sbdm_if, sbdm_table and sbdm_search
`timescale 1ns / 1ps

// Usage
// req_bus carries text bytes; a transaction with last_text set closes the text
// and starts a search. rsp_bus returns one transaction per text: the count of
// exact pattern occurrences (overlaps included, saturating at 8191) and a flag
// telling that bytes past TEXT_DEPTH were dropped.
// The csr port (csr_we, csr_index, csr_wdata) sets the four pattern words and
// the pattern length; write it only while the block is idle.
// Throughput: one text byte per cycle while loading. After the last byte the
// block drops ready for the table build (a scan for the longest run of
// distinct pattern bytes, then the position table fill) and then the search,
// which tests each window position, probes skips and compares bytes one at
// a time on the single registered read port of the text store; the result
// passes the hold state into the output register after the search engine
// flags done.
// Reset clears the csr registers (pattern length reads 1), the fill count and
// the position table valid bits. The text store itself is not cleared.
// A stalled result sits in the output register; loading of the next text goes
// on, and only a finished search waits for that register to drain.

module backward_snr_dawg_match_count_top #(
   parameter int TEXT_DEPTH = sbdm_pkg::TEXT_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   sbdm_req_if.sink                        req_bus,
   sbdm_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [sbdm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbdm_pkg::CSR_W-1:0]      csr_wdata
);
   import sbdm_pkg::*;

   localparam int AW = $clog2(TEXT_DEPTH);
   localparam int NW = $clog2(TEXT_DEPTH + 1);

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_BUILD  = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_HOLD   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CSR_W-1:0]   pat_a_ff, pat_b_ff, pat_c_ff, pat_d_ff;
   logic [5:0]         pat_len_ff;
   logic [NW-1:0]      fill_ff, fill_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               accept, full, mem_we, rsp_load;
   logic [5:0]         m_len;
   pattern_type        pattern;
   window_type         window;
   logic               build_start, build_done, search_start, search_done;
   logic [AW-1:0]      text_addr;
   logic [7:0]         text_q;
   logic [7:0]         tbl_addr;
   logic               tbl_hit;
   logic [4:0]         tbl_pos;
   logic [COUNT_W-1:0] search_count;
   logic [7:0]         text_mem [TEXT_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_a_ff   <= '0;
         pat_b_ff   <= '0;
         pat_c_ff   <= '0;
         pat_d_ff   <= '0;
         pat_len_ff <= 6'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAT_A:   pat_a_ff   <= csr_wdata;
            CSR_PAT_B:   pat_b_ff   <= csr_wdata;
            CSR_PAT_C:   pat_c_ff   <= csr_wdata;
            CSR_PAT_D:   pat_d_ff   <= csr_wdata;
            CSR_PAT_LEN: pat_len_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign pattern = pattern_type'({pat_d_ff, pat_c_ff, pat_b_ff, pat_a_ff});
   assign m_len   = (pat_len_ff == 6'd0) ? 6'd1
                  : (pat_len_ff > 6'(PATTERN_MAX)) ? 6'(PATTERN_MAX) : pat_len_ff;

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (fill_ff == NW'(TEXT_DEPTH));
   assign mem_we        = accept && !full;
   assign rsp_load      = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_bus.ready);
   assign build_start   = accept && req_bus.last_text;
   assign search_start  = build_done;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  fill_in = fill_ff + NW'(1);
               end
               if (req_bus.last_text) begin
                  state_in = ST_BUILD;
               end
            end
         end
         ST_BUILD:  if (build_done) state_in = ST_SEARCH;
         ST_SEARCH: if (search_done) state_in = ST_HOLD;
         ST_HOLD: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = search_count;
               rsp_ovf_in   = dropped_ff;
               fill_in      = '0;
               dropped_in   = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (mem_we) begin
         text_mem[fill_ff[AW-1:0]] <= req_bus.text_byte;
      end
      text_q <= text_mem[text_addr];
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.match_count   = rsp_count_ff;
   assign rsp_bus.text_overflow = rsp_ovf_ff;

   sbdm_table u_table (
      .clock   (clock),
      .reset   (reset),
      .start   (build_start),
      .pattern (pattern),
      .pat_len (m_len),
      .rd_addr (tbl_addr),
      .rd_hit  (tbl_hit),
      .rd_pos  (tbl_pos),
      .window  (window),
      .done    (build_done)
   );

   sbdm_search #(.TEXT_DEPTH(TEXT_DEPTH)) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (search_start),
      .pattern   (pattern),
      .pat_len   (m_len),
      .window    (window),
      .text_len  (fill_ff),
      .text_addr (text_addr),
      .text_q    (text_q),
      .tbl_addr  (tbl_addr),
      .tbl_hit   (tbl_hit),
      .tbl_pos   (tbl_pos),
      .done      (search_done),
      .count     (search_count)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NW'(TEXT_DEPTH))
      else $error("text fill beyond store depth");
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> full)
      else $error("drop flag set with room in the store");
   a_last_starts_build: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_text |=> state_ff == ST_BUILD)
      else $error("closing transaction did not start the build");
   a_search_done_state: assert property (@(posedge clock) disable iff (reset)
      search_done |-> state_ff == ST_SEARCH)
      else $error("search finished outside the search phase");
endmodule

[test/match_count_checker.sv]
// checker for the backward snr dawg match counter: mirrors the csr writes,
// predicts count and overflow per text and compares them with every rsp
// transaction; depends on sbdm_pkg and sbdm_if
`timescale 1ns / 1ps

module match_count_checker #(
   parameter int TEXT_DEPTH = sbdm_pkg::TEXT_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   sbdm_req_if                            req_bus,
   sbdm_rsp_if                            rsp_bus,
   input  logic                           csr_we,
   input  logic [sbdm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbdm_pkg::CSR_W-1:0]     csr_wdata,
   output int                             failures,
   output int                             pending,
   output int                             texts_checked,
   output int                             matches_seen,
   output int                             overflows_seen
);
   import sbdm_pkg::*;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } text_result_type;

   logic [3:0][CSR_W-1:0] pattern_words;
   logic [5:0]            pattern_len_reg;
   logic [7:0]            text_bytes [TEXT_DEPTH];
   int                    fill;
   bit                    dropped;
   text_result_type       expected_counts [$];

   task automatic report(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      failures++;
   endtask

   function automatic logic [7:0] pattern_byte(input int i);
      logic [255:0] flat;
      flat = pattern_words;
      return flat[8*i +: 8];
   endfunction

   // bytes past the text end read the pattern, then zero
   function automatic logic [7:0] byte_at(input int p, input int n, input int m);
      if (p < n)
         return text_bytes[p];
      if (p - n < m)
         return pattern_byte(p - n);
      return 8'd0;
   endfunction

   function automatic logic [COUNT_W-1:0] count_occurrences(input int n);
      int m, lo, best, wstart, offset, j, t, k, s, q;
      int count;
      int slot [256];
      bit seen [256];
      m = (pattern_len_reg == 0) ? 1 : (pattern_len_reg > PATTERN_MAX) ? PATTERN_MAX
                                                                      : pattern_len_reg;
      // longest run of distinct pattern bytes, first one wins
      lo = 0;
      best = 0;
      wstart = 0;
      for (int b = 0; b < 256; b++) begin
         seen[b] = 0;
         slot[b] = -1;
      end
      for (int i = 0; i < m; i++) begin
         if (seen[pattern_byte(i)]) begin
            while (pattern_byte(lo) != pattern_byte(i)) begin
               seen[pattern_byte(lo)] = 0;
               lo++;
            end
            seen[pattern_byte(i)] = 0;
            lo++;
         end
         seen[pattern_byte(i)] = 1;
         if (best < i - lo + 1) begin
            best = i - lo + 1;
            wstart = lo;
         end
      end
      for (int i = 0; i < best; i++)
         slot[pattern_byte(wstart + i)] = i;
      offset = wstart + best - 1;
      j = offset;
      count = 0;
      while (j < n) begin
         t = slot[byte_at(j, n, m)];
         while (t < 0) begin
            j += best;
            t = slot[byte_at(j, n, m)];
         end
         k = 1;
         while (k <= t && pattern_byte(wstart + t - k) == byte_at(j - k, n, m))
            k++;
         if (k > t) begin
            if (k == best) begin
               s = j - offset;
               if (s + m <= n) begin
                  q = 0;
                  while (q < m && text_bytes[s + q] == pattern_byte(q))
                     q++;
                  if (q == m && count < COUNT_MAX)
                     count++;
               end
            end else begin
               j -= k;
            end
         end
         j += best;
      end
      return count[COUNT_W-1:0];
   endfunction

   always @(posedge clock) begin
      text_result_type r, e;
      if (reset) begin
         pattern_words = '0;
         pattern_len_reg = 6'd1;
         fill = 0;
         dropped = 0;
         failures = 0;
         texts_checked = 0;
         matches_seen = 0;
         overflows_seen = 0;
         expected_counts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAT_A: pattern_words[0] = csr_wdata;
               CSR_PAT_B: pattern_words[1] = csr_wdata;
               CSR_PAT_C: pattern_words[2] = csr_wdata;
               CSR_PAT_D: pattern_words[3] = csr_wdata;
               CSR_PAT_LEN: pattern_len_reg = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_counts.size() == 0) begin
               report($sformatf("unexpected result count %0d", rsp_bus.match_count));
            end else begin
               e = expected_counts.pop_front();
               if (rsp_bus.match_count !== e.count)
                  report($sformatf("match_count %0d, expected %0d",
                                   rsp_bus.match_count, e.count));
               if (rsp_bus.text_overflow !== e.overflow)
                  report($sformatf("text_overflow %0b, expected %0b",
                                   rsp_bus.text_overflow, e.overflow));
               texts_checked++;
               matches_seen += e.count;
               overflows_seen += e.overflow;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (fill < TEXT_DEPTH) begin
               text_bytes[fill] = req_bus.text_byte;
               fill++;
            end else begin
               dropped = 1;
            end
            if (req_bus.last_text) begin
               r.count = count_occurrences(fill);
               r.overflow = dropped;
               expected_counts.push_back(r);
               fill = 0;
               dropped = 0;
            end
         end
      end
      pending = expected_counts.size();
   end

endmodule

[test/backward_snr_dawg_match_count_top_test.sv]
// testbench top for the backward snr dawg match counter: clock, reset, csr
// setup, text stimulus and result stalls; checking is in match_count_checker
// depends on sbdm_pkg, sbdm_if, the block and match_count_checker
`timescale 1ns / 1ps

module backward_snr_dawg_match_count_top_test;
   import sbdm_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   failures, pending, texts_checked, matches_seen, overflows_seen;
   int                   bytes_sent;
   bit                   gaps_on;
   pattern_type          pattern;
   int                   pattern_len;
   logic [7:0]           text_q [$];

   sbdm_req_if req_bus();
   sbdm_rsp_if rsp_bus();

   backward_snr_dawg_match_count_top i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   match_count_checker i_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending), .texts_checked(texts_checked),
      .matches_seen(matches_seen), .overflows_seen(overflows_seen)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: random stall before each transaction, sometimes none at all
   initial begin
      int n;
      bit stalls_on;
      rsp_bus.ready = 0;
      stalls_on = 1;
      forever begin
         if ($urandom_range(0, 9) == 0)
            stalls_on = !stalls_on;
         n = stalls_on ? $urandom_range(0, 4) : 0;
         repeat (n) begin
            @(negedge clock);
            rsp_bus.ready = 0;
         end
         @(negedge clock);
         rsp_bus.ready = 1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int n;
      n = gaps_on ? $urandom_range(0, 4) : 0;
      repeat (n) begin
         @(negedge clock);
         req_bus.valid = 0;
      end
      @(negedge clock);
      req_bus.valid = 1;
      req_bus.text_byte = b;
      req_bus.last_text = last;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i])
         send_byte(text_q[i], i == text_q.size() - 1);
      @(negedge clock);
      req_bus.valid = 0;
   endtask

   // hold off until every result is back, then give the search time to settle
   task automatic drain();
      while (pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // len_field goes to the length register as is, so 0 and 33..63 get exercised
   task automatic load_pattern(input logic [5:0] len_field);
      logic [255:0] flat;
      drain();
      flat = pattern;
      for (int w = 0; w < 4; w++) begin
         @(negedge clock);
         csr_we = 1;
         csr_index = CSR_PAT_A + CSR_IDX_W'(w);
         csr_wdata = flat[64*w +: 64];
      end
      @(negedge clock);
      csr_index = CSR_PAT_LEN;
      csr_wdata = {$urandom(), $urandom()};
      csr_wdata[5:0] = len_field;
      @(negedge clock);
      csr_we = 0;
      pattern_len = (len_field == 0) ? 1 : (len_field > PATTERN_MAX) ? PATTERN_MAX
                                                                     : len_field;
   endtask

   task automatic random_pattern();
      logic [7:0] pool [4];
      int k, sel;
      k = $urandom_range(1, 4);
      foreach (pool[i])
         pool[i] = $urandom();
      for (int i = 0; i < PATTERN_MAX; i++)
         pattern[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : pool[$urandom_range(0, k-1)];
      sel = $urandom_range(0, 9);
      case (sel)
         0: load_pattern(6'd0);
         1: load_pattern(6'd1);
         2: load_pattern(6'd32);
         3: load_pattern(6'($urandom_range(33, 63)));
         default: load_pattern(6'($urandom_range(1, 12)));
      endcase
   endtask

   // mostly pattern symbols and whole copies of the pattern, some noise
   task automatic build_text(input int len);
      int r;
      text_q.delete();
      while (text_q.size() < len) begin
         r = $urandom_range(0, 9);
         if (r < 3)
            for (int i = 0; i < pattern_len; i++)
               text_q.push_back(pattern[i]);
         else if (r < 9)
            text_q.push_back(pattern[$urandom_range(0, pattern_len - 1)]);
         else
            text_q.push_back(8'($urandom()));
      end
      while (text_q.size() > len)
         void'(text_q.pop_back());
   endtask

   initial begin
      int r, len;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_PAT_A;
      csr_wdata = '0;
      req_bus.valid = 0;
      req_bus.text_byte = '0;
      req_bus.last_text = 0;
      bytes_sent = 0;
      gaps_on = 1;
      pattern = '0;
      pattern_len = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset pattern, single-byte texts with extreme bytes
      text_q = '{8'h00};
      send_text();
      text_q = '{8'hff};
      send_text();
      // overlapping occurrences of a short pattern
      pattern = '0;
      pattern[0] = 8'h61;
      pattern[1] = 8'h62;
      pattern[2] = 8'h61;
      load_pattern(6'd3);
      text_q = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h61, 8'h62};
      send_text();
      // length zero acts as one, above the maximum acts as the maximum
      pattern[0] = 8'hff;
      load_pattern(6'd0);
      text_q = '{8'hff, 8'h7f, 8'hff, 8'hff};
      send_text();
      for (int i = 0; i < PATTERN_MAX; i++)
         pattern[i] = 8'h55 ^ 8'(i);
      load_pattern(6'd63);
      build_text(PATTERN_MAX);
      send_text();

      // random part
      while (bytes_sent < 1350) begin
         if ($urandom_range(0, 5) == 0)
            random_pattern();
         gaps_on = $urandom_range(0, 3) != 0;
         r = $urandom_range(0, 19);
         len = (r < 14) ? $urandom_range(1, 24) : (r < 19) ? $urandom_range(25, 80)
                                                           : $urandom_range(81, 300);
         build_text(len);
         send_text();
      end

      while (pending != 0)
         @(negedge clock);
      repeat (50) @(negedge clock);
      $display("checked %0d texts from %0d bytes: %0d occurrences, %0d overflowed texts",
               texts_checked, bytes_sent, matches_seen, overflows_seen);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
